/* hdl/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared codes and constants of the first-fit segment allocator: request
// function codes, register indexes, reset values and the arithmetic unit op.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

   localparam int FUNC_W    = 2;
   localparam int SIDX_W    = 8;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 1;
   localparam int SLACK_W   = 16;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_SLACK = 1'b1;

   localparam logic [CSR_W-1:0]   TOTAL_SIZE_RST  = 24'd65536;
   localparam logic [SLACK_W-1:0] SPLIT_SLACK_RST = 16'd256;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

`default_nettype wire

/* hdl/ffsa_ram.sv */
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

/* hdl/ffsa_alu.sv */
// ----------------------------------------------------------------------------
// ffsa_alu
// Shared add/subtract unit of the allocator. Operands are zero-extended by
// one bit, so the top bit of a subtraction is the borrow and the top bits of
// an addition are the carry.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_alu #(
   parameter int WIDTH = 25
) (
   input  wire ffsa_pkg::alu_op_type op,
   input  wire logic [WIDTH-1:0]     a,
   input  wire logic [WIDTH-1:0]     b,
   output logic      [WIDTH-1:0]     res
);

   import ffsa_pkg::*;

   always_comb begin
      unique case (op)
         ALU_ADD: res = a + b;
         ALU_SUB: res = a - b;
         default: res = a - b;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/first_fit_segment_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// Segment table (base, length and in-use flag in one RAM) with a first-fit
// allocate scan, split of large segments, free, fit query and reinit, all
// sequenced over one shared add/subtract unit.
// ----------------------------------------------------------------------------
// allocate: the scan reads one entry per cycle through the registered RAM port,
//   then the split check, append and commit follow; free of a live index goes
//   through the release step; fit query, reinit, zero-size allocate and
//   out-of-range free answer from idle; throughput: one word at a time,
//   busy holds until the result strobe cycle; reset: the init state writes
//   entry zero, busy is high during it; results cannot be stalled, so each is shown for exactly one cycle
`default_nettype none

module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = 64,
   parameter int ADDR_BITS    = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ffsa_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [ADDR_BITS-1:0]              req_size_bytes,
   input  wire logic [ffsa_pkg::SIDX_W-1:0]       req_segment_index,
   output logic                                   rsp_strobe,
   output logic                                   rsp_status,
   output logic [$clog2(MAX_SEGMENTS)-1:0]        rsp_granted_index,
   output logic [ADDR_BITS-1:0]                   rsp_granted_base,
   output logic [ADDR_BITS-1:0]                   rsp_free_total,
   input  wire logic                              csr_we,
   input  wire logic [ffsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ffsa_pkg::CSR_W-1:0]        csr_wdata
);

   import ffsa_pkg::*;

   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int CMP_W = (CNT_W > SIDX_W) ? CNT_W : SIDX_W;
   localparam int ALU_W = ((ADDR_BITS > SLACK_W) ? ADDR_BITS : SLACK_W) + 1;
   localparam int WORD_W = 2 * ADDR_BITS + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_SPLIT   = 3'd3;
   localparam logic [2:0] ST_APPEND  = 3'd4;
   localparam logic [2:0] ST_COMMIT  = 3'd5;
   localparam logic [2:0] ST_RELEASE = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [CSR_W-1:0]        total_size_ff;
   logic [SLACK_W-1:0]      split_slack_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_BITS-1:0]    free_ff, free_in;
   logic [ADDR_BITS-1:0]    size_ff, size_in;
   logic [IDX_W-1:0]        rel_idx_ff, rel_idx_in;
   logic [CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [ADDR_BITS-1:0]    hit_base_ff, hit_base_in;
   logic [ADDR_BITS-1:0]    spare_ff, spare_in;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [ADDR_BITS-1:0]    rsp_base_ff, rsp_base_in;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr, ram_raddr;
   logic [WORD_W-1:0]       ram_wdata, ram_rdata;
   logic [ADDR_BITS-1:0]    len_rd, base_rd;
   logic                    used_rd;

   alu_op_type              alu_op;
   logic [ALU_W-1:0]        alu_a, alu_b, alu_res;

   logic [ADDR_BITS-1:0]    total_addr, total_rst_addr;
   logic [CMP_W-1:0]        sidx_ext;
   logic                    free_ok;

   assign total_addr     = ADDR_BITS'(total_size_ff);
   assign total_rst_addr = ADDR_BITS'(TOTAL_SIZE_RST);
   assign len_rd         = ram_rdata[ADDR_BITS-1:0];
   assign base_rd        = ram_rdata[2*ADDR_BITS-1:ADDR_BITS];
   assign used_rd        = ram_rdata[WORD_W-1];
   assign sidx_ext       = CMP_W'(req_segment_index);
   // in-use flag is read from the table in the release step
   assign free_ok        = (sidx_ext < CMP_W'(count_ff));

   ffsa_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_SEGMENTS)
   ) u_seg_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   ffsa_alu #(
      .WIDTH(ALU_W)
   ) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .res(alu_res)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_size_ff  <= TOTAL_SIZE_RST;
         split_slack_ff <= SPLIT_SLACK_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_SIZE:  total_size_ff  <= csr_wdata;
            CSR_SPLIT_SLACK: split_slack_ff <= csr_wdata[SLACK_W-1:0];
            default:         total_size_ff  <= total_size_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      size_in       = size_ff;
      rel_idx_in    = rel_idx_ff;
      scan_idx_in   = scan_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = scan_idx_ff[IDX_W-1:0];
      hit_idx_in    = hit_idx_ff;
      hit_base_in   = hit_base_ff;
      spare_in      = spare_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = 1'b1;
      rsp_index_in  = '0;
      rsp_base_in   = '0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = scan_idx_ff[IDX_W-1:0];
      alu_op        = ALU_SUB;
      alu_a         = '0;
      alu_b         = '0;

      unique case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, {ADDR_BITS{1'b0}}, total_rst_addr};
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            ram_raddr = sidx_ext[IDX_W-1:0];
            alu_a     = ALU_W'(free_ff);
            alu_b     = ALU_W'(req_size_bytes);
            if (start) begin
               size_in    = req_size_bytes;
               rel_idx_in = sidx_ext[IDX_W-1:0];
               unique case (req_func)
                  FUNC_ALLOC: begin
                     if (req_size_bytes == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        scan_idx_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  FUNC_FREE: begin
                     if (free_ok) begin
                        state_in = ST_RELEASE;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  FUNC_REINIT: begin
                     // entries above zero are rewritten before they are read again
                     ram_we        = 1'b1;
                     ram_wdata     = {1'b0, {ADDR_BITS{1'b0}}, total_addr};
                     count_in      = ONE_CNT;
                     free_in       = total_addr;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = 1'b0;
                  end
                  FUNC_QUERY: begin
                     // borrow out of free - size means it does not fit
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = alu_res[ALU_W-1];
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            // read of entry n overlaps the length check of entry n - 1
            alu_a = ALU_W'(len_rd);
            alu_b = ALU_W'(size_ff);
            if (scan_idx_ff < count_ff) begin
               chk_valid_in = 1'b1;
               scan_idx_in  = scan_idx_ff + ONE_CNT;
            end
            priority if (chk_valid_ff && !used_rd && !alu_res[ALU_W-1]) begin
               hit_idx_in   = chk_idx_ff;
               hit_base_in  = base_rd;
               spare_in     = alu_res[ADDR_BITS-1:0];
               chk_valid_in = 1'b0;
               state_in     = ST_SPLIT;
            end else if (!chk_valid_ff && scan_idx_ff >= count_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SPLIT: begin
            alu_a = ALU_W'(spare_ff);
            alu_b = ALU_W'(split_slack_ff);
            if (!alu_res[ALU_W-1] && count_ff < MAX_CNT) begin
               state_in = ST_APPEND;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_APPEND: begin
            // spare bytes become a new free segment at the end of the table
            alu_op    = ALU_ADD;
            alu_a     = ALU_W'(hit_base_ff);
            alu_b     = ALU_W'(size_ff);
            ram_we    = 1'b1;
            ram_waddr = count_ff[IDX_W-1:0];
            ram_wdata = {1'b0, alu_res[ADDR_BITS-1:0], spare_ff};
            count_in  = count_ff + ONE_CNT;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            alu_a     = ALU_W'(free_ff);
            alu_b     = ALU_W'(size_ff);
            free_in   = alu_res[ALU_W-1] ? '0 : alu_res[ADDR_BITS-1:0];
            ram_we    = 1'b1;
            ram_waddr = hit_idx_ff;
            ram_wdata = {1'b1, hit_base_ff, size_ff};
            rsp_strobe_in = 1'b1;
            rsp_status_in = 1'b0;
            rsp_index_in  = hit_idx_ff;
            rsp_base_in   = hit_base_ff;
            state_in      = ST_IDLE;
         end
         ST_RELEASE: begin
            // saturate the free total on carry past the address width
            alu_op  = ALU_ADD;
            alu_a   = ALU_W'(free_ff);
            alu_b   = ALU_W'(len_rd);
            rsp_strobe_in = 1'b1;
            if (used_rd) begin
               free_in   = (|alu_res[ALU_W-1:ADDR_BITS]) ? '1 : alu_res[ADDR_BITS-1:0];
               ram_we    = 1'b1;
               ram_waddr = rel_idx_ff;
               ram_wdata = {1'b0, base_rd, len_rd};
               rsp_status_in = 1'b0;
            end
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         count_ff      <= ONE_CNT;
         free_ff       <= total_rst_addr;
         chk_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         free_ff       <= free_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      rel_idx_ff    <= rel_idx_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_base_ff   <= hit_base_in;
      spare_ff      <= spare_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_base_ff   <= rsp_base_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_granted_base  = rsp_base_ff;
   assign rsp_free_total    = free_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= MAX_CNT))
      else $error("segment count out of range");

   a_release_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELEASE) |-> (CNT_W'(rel_idx_ff) < count_ff))
      else $error("release of a segment beyond the live segments");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPEND) |-> (count_ff < MAX_CNT))
      else $error("segment appended to a full table");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_granted_index == '0) && (rsp_granted_base == '0))
      else $error("rejected word carries a grant");

   a_commit_grants: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> rsp_strobe && !rsp_status
         && (rsp_granted_index == $past(hit_idx_ff)))
      else $error("commit did not grant the segment");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit segment allocator. A behavioral
// segment table tracks every accepted request and predicts its response.
// Directed requests cover reset state, splits, dropped remainders,
// rejections and late register effects. Random phases then run under
// several register settings, including the extremes and a full table.
// ----------------------------------------------------------------------------

module tb;
   import ffsa_pkg::*;

   localparam int SEGS = 64;
   localparam int AW   = 24;
   localparam logic [AW-1:0] ADDR_MAX = '1;

   typedef struct packed {
      logic          status;
      logic [5:0]    index;
      logic [AW-1:0] base;
      logic [AW-1:0] free_total;
   } grant_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [FUNC_W-1:0]    req_func;
   logic [AW-1:0]        req_size_bytes;
   logic [SIDX_W-1:0]    req_segment_index;
   logic                 rsp_strobe;
   logic                 rsp_status;
   logic [5:0]           rsp_granted_index;
   logic [AW-1:0]        rsp_granted_base;
   logic [AW-1:0]        rsp_free_total;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // shadow of the segment table and registers
   logic [AW-1:0]      seg_base_q [SEGS];
   logic [AW-1:0]      seg_len_q  [SEGS];
   bit                 seg_used_q [SEGS];
   int                 seg_total;
   logic [AW-1:0]      free_shadow;
   logic [AW-1:0]      capacity;
   logic [SLACK_W-1:0] split_min;

   grant_type grants_due[$];
   grant_type head_grant;
   int        mismatches;
   bit        gaps_on;

   first_fit_segment_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_size_bytes    (req_size_bytes),
      .req_segment_index (req_segment_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_granted_base  (rsp_granted_base),
      .rsp_free_total    (rsp_free_total),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void restore_table();
      seg_base_q[0] = '0;
      seg_len_q[0]  = capacity;
      for (int k = 0; k < SEGS; k++) seg_used_q[k] = 1'b0;
      seg_total   = 1;
      free_shadow = capacity;
   endfunction

   function automatic grant_type next_grant(input logic [FUNC_W-1:0] fn,
                                            input logic [AW-1:0] sz,
                                            input logic [SIDX_W-1:0] idx);
      grant_type   g;
      int          i;
      bit          done;
      logic [AW:0] sum;
      g        = '0;
      g.status = 1'b1;
      done     = 1'b0;
      case (fn)
         FUNC_ALLOC: begin
            if (sz != '0) begin
               for (i = 0; i < seg_total && !done; i++) begin
                  if (!seg_used_q[i] && seg_len_q[i] >= sz) begin
                     // remainder becomes a new free segment only with room and slack
                     if ({1'b0, seg_len_q[i]} >= {1'b0, sz} + split_min
                         && seg_total < SEGS) begin
                        seg_base_q[seg_total] = seg_base_q[i] + sz;
                        seg_len_q[seg_total]  = seg_len_q[i] - sz;
                        seg_used_q[seg_total] = 1'b0;
                        seg_total++;
                     end
                     seg_len_q[i]  = sz;
                     seg_used_q[i] = 1'b1;
                     free_shadow   = (free_shadow >= sz) ? free_shadow - sz : '0;
                     g.status      = 1'b0;
                     g.index       = i[5:0];
                     g.base        = seg_base_q[i];
                     done          = 1'b1;
                  end
               end
            end
         end
         FUNC_FREE: begin
            if (idx < seg_total && seg_used_q[idx]) begin
               sum             = free_shadow + seg_len_q[idx];
               free_shadow     = sum[AW] ? ADDR_MAX : sum[AW-1:0];
               seg_used_q[idx] = 1'b0;
               g.status        = 1'b0;
            end
         end
         FUNC_REINIT: begin
            restore_table();
            g.status = 1'b0;
         end
         default: g.status = (free_shadow >= sz) ? 1'b0 : 1'b1;
      endcase
      g.free_total = free_shadow;
      return g;
   endfunction

   // random segment with the wanted in-use flag, -1 if none
   function automatic int pick_segment(input bit want_used);
      int j;
      int k;
      j = $urandom_range(seg_total - 1);
      for (k = 0; k < seg_total; k++) begin
         if (seg_used_q[(j + k) % seg_total] == want_used) return (j + k) % seg_total;
      end
      return -1;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (grants_due.size() == 0) begin
            $error("response word with no request outstanding");
            mismatches++;
         end else begin
            head_grant = grants_due.pop_front();
            if (rsp_status !== head_grant.status) begin
               $error("status: expected %0h, got %0h", head_grant.status, rsp_status);
               mismatches++;
            end
            if (rsp_granted_index !== head_grant.index) begin
               $error("granted_index: expected %0d, got %0d",
                      head_grant.index, rsp_granted_index);
               mismatches++;
            end
            if (rsp_granted_base !== head_grant.base) begin
               $error("granted_base: expected %0h, got %0h",
                      head_grant.base, rsp_granted_base);
               mismatches++;
            end
            if (rsp_free_total !== head_grant.free_total) begin
               $error("free_total: expected %0h, got %0h",
                      head_grant.free_total, rsp_free_total);
               mismatches++;
            end
         end
      end
   end

   // called and returns at a falling edge
   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [AW-1:0] sz,
                               input logic [SIDX_W-1:0] idx);
      bit taken;
      req_func          = fn;
      req_size_bytes    = sz;
      req_segment_index = idx;
      taken             = 1'b0;
      while (!taken) begin
         start = !(gaps_on && $urandom_range(99) < 26);
         taken = start && (busy === 1'b0);
         @(posedge clock);
         if (!taken) @(negedge clock);
      end
      grants_due.push_back(next_grant(fn, sz, idx));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_TOTAL_SIZE) capacity = val;
      else split_min = val[SLACK_W-1:0];
   endtask

   task automatic drain_results();
      while (grants_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_random(input int alloc_pct, input int reinit_pct);
      int                roll;
      int                pick;
      logic [FUNC_W-1:0] fn;
      logic [AW-1:0]     sz;
      logic [SIDX_W-1:0] idx;
      roll = $urandom_range(99);
      sz   = AW'($urandom());
      idx  = SIDX_W'($urandom());
      if (roll < alloc_pct) begin
         fn = FUNC_ALLOC;
         case ($urandom_range(9))
            0: sz = '0;
            1: ;
            2, 3: begin
               pick = pick_segment(1'b0);
               if (pick >= 0) sz = seg_len_q[pick];
            end
            default: sz = AW'($urandom_range(1, (capacity > 16) ? capacity / 16 : 1));
         endcase
      end else if (roll < alloc_pct + (100 - alloc_pct - reinit_pct) * 2 / 3) begin
         fn   = FUNC_FREE;
         pick = pick_segment(1'b1);
         if (pick >= 0 && $urandom_range(9) < 8) idx = SIDX_W'(pick);
      end else if (roll < 100 - reinit_pct) begin
         fn = FUNC_QUERY;
         case ($urandom_range(2))
            0: sz = free_shadow;
            1: sz = free_shadow + 1'b1;
            default: ;
         endcase
      end else begin
         fn = FUNC_REINIT;
      end
      send_request(fn, sz, idx);
   endtask

   task automatic run_phase(input logic [AW-1:0] cap, input logic [SLACK_W-1:0] slack,
                            input int items, input int alloc_pct, input int reinit_pct,
                            input bit idle_on, input bit mid_drain);
      int n;
      drain_results();
      write_csr(CSR_TOTAL_SIZE, cap);
      write_csr(CSR_SPLIT_SLACK, CSR_W'(slack));
      gaps_on = idle_on;
      send_request(FUNC_REINIT, '0, '0);
      for (n = 0; n < items; n++) begin
         if (mid_drain && n == items / 2) drain_results();
         send_random(alloc_pct, reinit_pct);
      end
   endtask

   task automatic test_reset_state();
      send_request(FUNC_QUERY, '0, '0);
      send_request(FUNC_QUERY, 24'd65536, '0);
      send_request(FUNC_QUERY, 24'd65537, '0);
      send_request(FUNC_QUERY, ADDR_MAX, '0);
      send_request(FUNC_ALLOC, '0, '0);
      send_request(FUNC_FREE, '0, '0);
      send_request(FUNC_FREE, '0, 8'hFF);
   endtask

   task automatic test_alloc_free();
      send_request(FUNC_ALLOC, 24'd100, '0);
      send_request(FUNC_ALLOC, ADDR_MAX, '0);
      // spare below slack, remainder dropped
      send_request(FUNC_ALLOC, 24'd65300, '0);
      send_request(FUNC_ALLOC, 24'd1, '0);
      send_request(FUNC_FREE, '0, 8'd1);
      send_request(FUNC_FREE, '0, 8'd1);
      send_request(FUNC_FREE, '0, 8'd2);
      send_request(FUNC_FREE, '0, 8'd0);
      send_request(FUNC_ALLOC, 24'd50, 8'hAA);
      send_request(FUNC_QUERY, 24'h00FFFF, 8'h55);
      send_request(FUNC_REINIT, '0, '0);
   endtask

   // new capacity only shows after a reinit
   task automatic test_capacity_change();
      drain_results();
      write_csr(CSR_TOTAL_SIZE, 24'd1000);
      send_request(FUNC_QUERY, 24'd65536, '0);
      send_request(FUNC_REINIT, '0, '0);
      send_request(FUNC_QUERY, 24'd1000, '0);
      send_request(FUNC_QUERY, 24'd1001, '0);
   endtask

   task automatic test_default_split();
      run_phase(TOTAL_SIZE_RST, SPLIT_SLACK_RST, 100, 50, 3, 1'b1, 1'b1);
   endtask

   task automatic test_table_full();
      run_phase(24'd4096, '0, 120, 65, 0, 1'b1, 1'b0);
   endtask

   task automatic test_register_max();
      run_phase(ADDR_MAX, '1, 100, 50, 2, 1'b0, 1'b0);
   endtask

   task automatic test_register_min();
      run_phase(24'd1, '0, 40, 50, 3, 1'b1, 1'b0);
   endtask

   task automatic test_random_registers();
      run_phase(AW'($urandom_range(1, 24'hFFFFFF)), SLACK_W'($urandom_range(0, 16'hFFFF)),
                120, 50, 2, 1'b1, 1'b1);
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_func          = FUNC_ALLOC;
      req_size_bytes    = '0;
      req_segment_index = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_TOTAL_SIZE;
      csr_wdata         = '0;
      mismatches        = 0;
      gaps_on           = 1'b1;
      capacity          = TOTAL_SIZE_RST;
      split_min         = SPLIT_SLACK_RST;
      restore_table();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_alloc_free();
      test_capacity_change();
      test_default_split();
      test_table_full();
      test_register_max();
      test_register_min();
      test_random_registers();

      drain_results();
      // watch for stray words
      repeat (80) @(negedge clock);
      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
hdl/ffsa_pkg.sv
hdl/ffsa_ram.sv
hdl/ffsa_alu.sv
hdl/first_fit_segment_allocator.sv
tb/tb.sv
